FILE: design/blt_pkg.sv
// blt_pkg: shared constants and codes for the bucketed lock table
// no dependencies; used by bucketed_lock_table and its checker
package blt_pkg;

  localparam int Buckets        = 16;
  localparam int SlotsPerBucket = 8;
  localparam int BucketBits     = 4;

  localparam int IdxW   = 32;
  localparam int BktW   = $clog2(Buckets);
  localparam int SlotW  = $clog2(SlotsPerBucket);
  localparam int RslotW = 3;
  localparam int StatW  = 2;
  localparam int GslotW = 3;

  localparam logic [IdxW-1:0] EmptySlot = '1;

  // command codes carried on the request tuser
  localparam logic CmdAcquire = 1'b0;
  localparam logic CmdRelease = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] StGranted = 2'd0;
  localparam logic [StatW-1:0] StHeld    = 2'd1;
  localparam logic [StatW-1:0] StFull    = 2'd2;

  // stream data widths, packed and padded to whole bytes
  localparam int InDataW  = ((IdxW + RslotW + 7) / 8) * 8;
  localparam int OutDataW = ((GslotW + IdxW + 7) / 8) * 8;

endpackage

FILE: design/bucketed_lock_table.sv
// bucketed_lock_table: set-associative lock table for memory block indexes
// depends on blt_pkg; slot contents held in an internal row memory
//
// flow: a request and its bucket row are registered at acceptance; only an
//   acquire gives a result, registered when the result register is free
// throughput: one request per cycle unless an acquire waits on a stalled
//   result; every slot of the row is compared in parallel in the following cycle
// reset: asynchronous, active low; occupancy flags clear at once so every
//   slot reads as empty, with no clearing pass over the row memory
module bucketed_lock_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] block_index, [34:32] release_slot, [39:35] zero
  input  logic [blt_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                         s_axis_tuser,
  // result channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] granted_slot, [34:3] granted_index, [39:35] zero
  output logic [blt_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [blt_pkg::StatW-1:0]    m_axis_tuser
);

  localparam int IdxW  = blt_pkg::IdxW;
  localparam int BktW  = blt_pkg::BktW;
  localparam int SlotW = blt_pkg::SlotW;
  localparam int Slots = blt_pkg::SlotsPerBucket;

  // row memory: one row per bucket, one word per slot
  logic [IdxW-1:0] table_mem [blt_pkg::Buckets][Slots];

  // occupancy flags; a clear flag means the slot reads as all ones
  logic [blt_pkg::Buckets-1:0][Slots-1:0] occ_q, occ_d;

  // request register
  logic                       s1_valid_q;
  logic                       s1_cmd_q;
  logic [IdxW-1:0]            s1_idx_q;
  logic [blt_pkg::RslotW-1:0] s1_rslot_q;
  logic [IdxW-1:0]            row_q [Slots];

  // last word written to the row memory, to cover the read that
  // happens at the same edge as that write
  logic             byp_valid_q;
  logic [BktW-1:0]  byp_bkt_q;
  logic [SlotW-1:0] byp_slot_q;
  logic [IdxW-1:0]  byp_val_q;

  // result register
  logic                        out_valid_q;
  logic [blt_pkg::StatW-1:0]   out_stat_q;
  logic [blt_pkg::GslotW-1:0]  out_slot_q;
  logic [IdxW-1:0]             out_idx_q;

  logic                         in_fire;
  logic                         s1_fire;
  logic                         out_free;
  logic [blt_pkg::BucketBits-1:0] in_bkt_full;
  logic [blt_pkg::BucketBits-1:0] s1_bkt_full;
  logic [BktW-1:0]              in_bkt;
  logic [BktW-1:0]              s1_bkt;
  logic                         s1_bkt_ok;
  logic                         rslot_ok;
  logic [IdxW-1:0]              slot_val [Slots];
  logic                         held;
  logic                         have_free;
  logic [SlotW-1:0]             free_pos;
  logic                         grant;
  logic [blt_pkg::StatW-1:0]    res_stat;

  // bucket select from the low index bits
  assign in_bkt_full = s_axis_tdata[blt_pkg::BucketBits-1:0];
  assign in_bkt      = in_bkt_full[BktW-1:0];
  assign s1_bkt_full = s1_idx_q[blt_pkg::BucketBits-1:0];
  assign s1_bkt      = s1_bkt_full[BktW-1:0];
  assign s1_bkt_ok   = 32'(s1_bkt_full) < blt_pkg::Buckets;
  assign rslot_ok    = 32'(s1_rslot_q) < Slots;

  // releases never need the result register
  assign out_free = !out_valid_q || m_axis_tready;
  assign s1_fire  = s1_valid_q && ((s1_cmd_q == blt_pkg::CmdRelease) || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // slot compare across the bucket, highest free slot wins
  always_comb begin
    held      = 1'b0;
    have_free = 1'b0;
    free_pos  = '0;
    for (int i = 0; i < Slots; i++) begin
      if (byp_valid_q && byp_bkt_q == s1_bkt && byp_slot_q == SlotW'(i)) begin
        slot_val[i] = occ_q[s1_bkt][i] ? byp_val_q : blt_pkg::EmptySlot;
      end else begin
        slot_val[i] = occ_q[s1_bkt][i] ? row_q[i] : blt_pkg::EmptySlot;
      end
      if (slot_val[i] == s1_idx_q) begin
        held = 1'b1;
      end
      if (slot_val[i] == blt_pkg::EmptySlot) begin
        have_free = 1'b1;
        free_pos  = SlotW'(i);
      end
    end
  end

  always_comb begin
    grant    = 1'b0;
    res_stat = blt_pkg::StFull;
    if (s1_bkt_ok) begin
      if (held) begin
        res_stat = blt_pkg::StHeld;
      end else if (have_free) begin
        res_stat = blt_pkg::StGranted;
        grant    = 1'b1;
      end
    end
  end

  // occupancy update: release clears a flag, a grant sets one
  always_comb begin
    occ_d = occ_q;
    if (s1_fire && s1_bkt_ok) begin
      if (s1_cmd_q == blt_pkg::CmdRelease) begin
        if (rslot_ok) begin
          occ_d[s1_bkt][s1_rslot_q[SlotW-1:0]] = 1'b0;
        end
      end else if (grant) begin
        occ_d[s1_bkt][free_pos] = 1'b1;
      end
    end
  end

  // row memory: written on a grant, row read on acceptance
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_cmd_q == blt_pkg::CmdAcquire && grant) begin
      table_mem[s1_bkt][free_pos] <= s1_idx_q;
    end
    if (in_fire) begin
      for (int i = 0; i < Slots; i++) begin
        row_q[i] <= table_mem[in_bkt][i];
      end
    end
  end

  // request payload, bypass payload and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= s_axis_tuser;
      s1_idx_q   <= s_axis_tdata[IdxW-1:0];
      s1_rslot_q <= s_axis_tdata[IdxW +: blt_pkg::RslotW];
    end
    if (s1_fire && s1_cmd_q == blt_pkg::CmdAcquire && grant) begin
      byp_bkt_q  <= s1_bkt;
      byp_slot_q <= free_pos;
      byp_val_q  <= s1_idx_q;
    end
    if (s1_fire && s1_cmd_q == blt_pkg::CmdAcquire) begin
      out_stat_q <= res_stat;
      out_slot_q <= grant ? blt_pkg::GslotW'(free_pos) : '0;
      out_idx_q  <= s1_idx_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_cmd_q == blt_pkg::CmdAcquire && grant) begin
        byp_valid_q <= 1'b1;
      end
      if (s1_fire && s1_cmd_q == blt_pkg::CmdAcquire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {{(blt_pkg::OutDataW - blt_pkg::GslotW - IdxW){1'b0}},
                          out_idx_q, out_slot_q};

endmodule

FILE: design/blt_checker.sv
// blt_checker: port-level assertions for bucketed_lock_table
// depends on blt_pkg; bound to the top level below
module blt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [blt_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [blt_pkg::StatW-1:0]    m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // only the three defined status codes appear
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == blt_pkg::StGranted ||
                       m_axis_tuser == blt_pkg::StHeld ||
                       m_axis_tuser == blt_pkg::StFull))
    else $error("undefined status code");

  // a busy answer reports slot zero
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != blt_pkg::StGranted |->
      m_axis_tdata[blt_pkg::GslotW-1:0] == '0)
    else $error("busy result with non-zero slot");

  // the empty marker can never be granted
  a_nomark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == blt_pkg::StGranted |->
      m_axis_tdata[blt_pkg::GslotW +: blt_pkg::IdxW] != blt_pkg::EmptySlot)
    else $error("empty marker granted");

endmodule

bind bucketed_lock_table blt_checker u_blt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
